// ----- src/tdpq_pkg.sv -----
package tdpq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned NumCfgRegs = 6;
  localparam logic [19:0] UsecPerSec = 20'd1000000;
  localparam logic [28:0] UsecRecip = 29'd281474977;

  typedef enum logic [1:0] {
    OP_ADD_KIND = 2'd0,
    OP_ADD_MS   = 2'd1,
    OP_POP      = 2'd2,
    OP_PEEK     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_BIND_MIN  = 3'd0,
    REG_BIND_SPAN = 3'd1,
    REG_CONN      = 3'd2,
    REG_ANSWER    = 3'd3,
    REG_KEEP      = 3'd4,
    REG_EVENT     = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_NORM,
    S_SCAN,
    S_SHIFT,
    S_POP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] sec;
    logic [19:0] usec;
    logic [2:0]  kind;
    logic [15:0] tag;
  } entry_t;

endpackage

// ----- src/tdpq_deadline.sv -----
module tdpq_deadline (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [63:0] total_i,
  input  logic [31:0] now_sec_i,
  output logic        done_o,
  output logic [31:0] sec_o,
  output logic [19:0] usec_o
);

  logic [33:0] tot_q, tot_d;
  logic [14:0] quo_q, quo_d;
  logic [19:0] rem_q, rem_d;
  logic [1:0]  step_q, step_d;
  logic [56:0] prod;
  logic [33:0] back;

  // split total microseconds: drop the factor 64, multiply by the reciprocal of 15625
  always_comb begin
    tot_d  = tot_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    prod = {29'd0, tot_q[33:6]} * {28'd0, tdpq_pkg::UsecRecip};
    back = tot_q - {19'd0, quo_q} * 34'(tdpq_pkg::UsecPerSec);
    if (load_i) begin
      tot_d  = total_i[33:0];
      step_d = 2'd2;
    end else begin
      case (step_q)
        2'd2: begin
          quo_d  = prod[56:42];
          step_d = 2'd1;
        end
        2'd1: begin
          rem_d  = back[19:0];
          step_d = 2'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      step_q <= '0;
    end else begin
      tot_q  <= tot_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      step_q <= step_d;
    end
  end

  assign done_o = (step_q == 2'd0) && !load_i;
  assign sec_o  = now_sec_i + {17'd0, quo_q};
  assign usec_o = rem_q;

endmodule

// ----- src/timer_deadline_priority_queue.sv -----
// Busy is high from the accepting edge until the valid_o cycle. An add to a full queue goes
// straight to the result; other adds run the delay sum, seconds split, scan and shift.
// One item at a time; start may be taken again in the valid_o cycle.
// The time taken comes from the reciprocal seconds split and the one-entry-per-step scan/shift loop.
// Result is shown for one cycle on valid_o; the receiver cannot stall.
// Reset clears the task count and loads the register defaults; entries stay unset.
module timer_deadline_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = tdpq_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] now_sec_i,
  input  logic [19:0] now_usec_i,
  input  logic [2:0]  task_kind_i,
  input  logic [22:0] delay_ms_i,
  input  logic [15:0] random_word_i,
  input  logic [15:0] user_tag_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic        task_valid_o,
  output logic [2:0]  out_kind_o,
  output logic [15:0] out_tag_o,
  output logic [31:0] due_sec_o,
  output logic [19:0] due_usec_o,
  output logic [4:0]  occupancy_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  tdpq_pkg::state_e state_q, state_d;
  logic [31:0] regs_q [tdpq_pkg::NumCfgRegs];
  tdpq_pkg::entry_t ent_q [QUEUE_DEPTH];
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] pos_q;
  logic [1:0]  op_q;
  logic [31:0] nsec_q;
  logic [19:0] nusec_q;
  logic [2:0]  kind_q;
  logic [15:0] tag_q;
  logic [15:0] rnd_q;
  logic [63:0] acc_q;
  logic [1:0]  ost_q;
  logic        otv_q;
  tdpq_pkg::entry_t oent_q;
  logic        ov_q;
  logic        div_load_q;

  logic accept;
  logic div_load, div_done;
  logic [31:0] dsec;
  logic [19:0] dusec;
  logic [63:0] mul;
  logic scan_earlier;
  tdpq_pkg::entry_t cur;

  assign accept = start && !busy;
  assign busy = (state_q != tdpq_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign mul = {32'd0, regs_q[tdpq_pkg::REG_BIND_SPAN]} * {48'd0, rnd_q};
  assign cur = ent_q[pos_q[AW-1:0]];
  assign scan_earlier = (cur.sec != dsec) ? (cur.sec < dsec) : (cur.usec < dusec);
  assign div_load = div_load_q;

  tdpq_deadline u_dl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (div_load),
    .total_i  (acc_q),
    .now_sec_i(nsec_q),
    .done_o   (div_done),
    .sec_o    (dsec),
    .usec_o   (dusec)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      tdpq_pkg::S_IDLE: begin
        if (accept) begin
          if (opcode_i == tdpq_pkg::OP_POP || opcode_i == tdpq_pkg::OP_PEEK) begin
            state_d = tdpq_pkg::S_POP;
          end else if (cnt_q >= CW'(QUEUE_DEPTH)) begin
            state_d = tdpq_pkg::S_DONE;
          end else begin
            state_d = tdpq_pkg::S_MUL;
          end
        end
      end
      tdpq_pkg::S_MUL:   state_d = tdpq_pkg::S_NORM;
      tdpq_pkg::S_NORM:  if (div_done) state_d = tdpq_pkg::S_SCAN;
      tdpq_pkg::S_SCAN: begin
        if (!(pos_q < cnt_q && scan_earlier)) state_d = tdpq_pkg::S_SHIFT;
      end
      tdpq_pkg::S_SHIFT: if (!(acc_q[CW-1:0] > pos_q)) state_d = tdpq_pkg::S_DONE;
      tdpq_pkg::S_POP: begin
        if (op_q != tdpq_pkg::OP_POP || cnt_q == '0 || pos_q + CW'(1) >= cnt_q)
          state_d = tdpq_pkg::S_DONE;
      end
      tdpq_pkg::S_DONE:  state_d = tdpq_pkg::S_IDLE;
      default:           state_d = tdpq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdpq_pkg::S_IDLE;
      cnt_q <= '0;
      ov_q <= 1'b0;
      div_load_q <= 1'b0;
      regs_q[tdpq_pkg::REG_BIND_MIN]  <= 32'd20000;
      regs_q[tdpq_pkg::REG_BIND_SPAN] <= 32'd20000;
      regs_q[tdpq_pkg::REG_CONN]      <= 32'd1000000;
      regs_q[tdpq_pkg::REG_ANSWER]    <= 32'd1000000;
      regs_q[tdpq_pkg::REG_KEEP]      <= 32'd15000000;
      regs_q[tdpq_pkg::REG_EVENT]     <= 32'd0;
    end else begin
      state_q <= state_d;
      ov_q <= (state_q == tdpq_pkg::S_DONE);
      div_load_q <= (state_q == tdpq_pkg::S_MUL);
      if (cfg_valid_i && cfg_index_i < 3'(tdpq_pkg::NumCfgRegs))
        regs_q[cfg_index_i] <= cfg_data_i;
      if (state_q == tdpq_pkg::S_SHIFT && !(acc_q[CW-1:0] > pos_q)) cnt_q <= cnt_q + CW'(1);
      if (state_q == tdpq_pkg::S_POP && state_d == tdpq_pkg::S_DONE &&
          op_q == tdpq_pkg::OP_POP && cnt_q != '0) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tdpq_pkg::S_IDLE: begin
        op_q <= opcode_i;
        nsec_q <= now_sec_i;
        nusec_q <= now_usec_i;
        kind_q <= task_kind_i;
        tag_q <= user_tag_i;
        rnd_q <= random_word_i;
        pos_q <= '0;
        ost_q <= tdpq_pkg::ST_FULL;
        otv_q <= 1'b0;
        oent_q <= '0;
        acc_q <= 64'(delay_ms_i) * 64'd1000;
      end
      tdpq_pkg::S_MUL: begin
        if (op_q == tdpq_pkg::OP_ADD_KIND) begin
          case (kind_q)
            3'd0: acc_q <= 64'(nusec_q) + 64'(regs_q[tdpq_pkg::REG_BIND_MIN]) +
                           {16'd0, mul[63:16]};
            3'd1: acc_q <= 64'(nusec_q) + 64'(regs_q[tdpq_pkg::REG_CONN]);
            3'd2: acc_q <= 64'(nusec_q) + 64'(regs_q[tdpq_pkg::REG_ANSWER]);
            3'd3: acc_q <= 64'(nusec_q) + 64'(regs_q[tdpq_pkg::REG_KEEP]);
            3'd4: acc_q <= 64'(nusec_q) + 64'(regs_q[tdpq_pkg::REG_EVENT]);
            default: acc_q <= 64'(nusec_q);
          endcase
        end else begin
          acc_q <= acc_q + 64'(nusec_q);
        end
      end
      tdpq_pkg::S_SCAN: begin
        if (pos_q < cnt_q && scan_earlier) pos_q <= pos_q + CW'(1);
        else acc_q <= 64'(cnt_q);
      end
      tdpq_pkg::S_SHIFT: begin
        if (acc_q[CW-1:0] > pos_q) begin
          ent_q[acc_q[AW-1:0]] <= ent_q[acc_q[AW-1:0] - AW'(1)];
          acc_q <= acc_q - 64'd1;
        end else begin
          ent_q[pos_q[AW-1:0]] <= '{sec: dsec, usec: dusec, kind: kind_q, tag: tag_q};
          ost_q <= tdpq_pkg::ST_OK;
          oent_q <= '{sec: dsec, usec: dusec, kind: 3'd0, tag: 16'd0};
        end
      end
      tdpq_pkg::S_POP: begin
        if (pos_q == '0) begin
          if (cnt_q == '0) begin
            ost_q <= tdpq_pkg::ST_EMPTY;
          end else begin
            ost_q <= tdpq_pkg::ST_OK;
            otv_q <= 1'b1;
            oent_q <= ent_q[0];
          end
        end
        if (op_q == tdpq_pkg::OP_POP && pos_q + CW'(1) < cnt_q) begin
          ent_q[pos_q[AW-1:0]] <= ent_q[pos_q[AW-1:0] + AW'(1)];
          pos_q <= pos_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign valid_o      = ov_q;
  assign status_o     = ost_q;
  assign task_valid_o = otv_q;
  assign out_kind_o   = oent_q.kind;
  assign out_tag_o    = oent_q.tag;
  assign due_sec_o    = oent_q.sec;
  assign due_usec_o   = oent_q.usec;
  assign occupancy_o  = 5'(cnt_q);

endmodule

// ----- dv/testbench.sv -----
module testbench;
  import tdpq_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct packed {
    logic [1:0]  status;
    logic        task_valid;
    logic [2:0]  kind;
    logic [15:0] tag;
    logic [31:0] due_sec;
    logic [19:0] due_usec;
    logic [4:0]  occupancy;
  } timer_answer_t;

  class timer_scoreboard;
    logic [31:0]   delay_reg [NumCfgRegs];
    entry_t        held [$];
    timer_answer_t pending [$];
    int            mismatches;

    function void clear();
      delay_reg[REG_BIND_MIN]  = 32'd20000;
      delay_reg[REG_BIND_SPAN] = 32'd20000;
      delay_reg[REG_CONN]      = 32'd1000000;
      delay_reg[REG_ANSWER]    = 32'd1000000;
      delay_reg[REG_KEEP]      = 32'd15000000;
      delay_reg[REG_EVENT]     = 32'd0;
      held.delete();
      pending.delete();
      mismatches = 0;
    endfunction

    function logic [63:0] kind_delay(logic [2:0] kind, logic [15:0] rnd);
      logic [63:0] scaled;
      scaled = 64'(delay_reg[REG_BIND_SPAN]) * 64'(rnd);
      case (kind)
        3'd0: kind_delay = 64'(delay_reg[REG_BIND_MIN]) + (scaled >> 16);
        3'd1: kind_delay = 64'(delay_reg[REG_CONN]);
        3'd2: kind_delay = 64'(delay_reg[REG_ANSWER]);
        3'd3: kind_delay = 64'(delay_reg[REG_KEEP]);
        3'd4: kind_delay = 64'(delay_reg[REG_EVENT]);
        default: kind_delay = 64'd0;
      endcase
    endfunction

    function void note_item(op_e op, logic [31:0] now_s, logic [19:0] now_u,
                            logic [2:0] kind, logic [22:0] dms, logic [15:0] rnd,
                            logic [15:0] tag);
      timer_answer_t a;
      logic [63:0] total;
      entry_t e;
      int pos;
      a = '0;
      if (op == OP_ADD_KIND || op == OP_ADD_MS) begin
        if (held.size() >= Depth) begin
          a.status = ST_FULL;
        end else begin
          total = 64'(now_u) + ((op == OP_ADD_KIND) ? kind_delay(kind, rnd)
                                                    : 64'(dms) * 64'd1000);
          e.sec  = now_s + 32'(total / 64'd1000000);
          e.usec = 20'(total % 64'd1000000);
          e.kind = kind;
          e.tag  = tag;
          pos = 0;
          while (pos < held.size() && (held[pos].sec < e.sec ||
                 (held[pos].sec == e.sec && held[pos].usec < e.usec)))
            pos++;
          held.insert(pos, e);
          a.status   = ST_OK;
          a.due_sec  = e.sec;
          a.due_usec = e.usec;
        end
      end else if (held.size() == 0) begin
        a.status = ST_EMPTY;
      end else begin
        a.status     = ST_OK;
        a.task_valid = 1'b1;
        a.kind       = held[0].kind;
        a.tag        = held[0].tag;
        a.due_sec    = held[0].sec;
        a.due_usec   = held[0].usec;
        if (op == OP_POP) void'(held.pop_front());
      end
      a.occupancy = 5'(held.size());
      pending.push_back(a);
    endfunction

    function void check_answer(timer_answer_t got);
      timer_answer_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic [1:0]  opcode_i = '0;
  logic [31:0] now_sec_i = '0;
  logic [19:0] now_usec_i = '0;
  logic [2:0]  task_kind_i = '0;
  logic [22:0] delay_ms_i = '0;
  logic [15:0] random_word_i = '0;
  logic [15:0] user_tag_i = '0;
  logic        valid_o;
  logic [1:0]  status_o;
  logic        task_valid_o;
  logic [2:0]  out_kind_o;
  logic [15:0] out_tag_o;
  logic [31:0] due_sec_o;
  logic [19:0] due_usec_o;
  logic [4:0]  occupancy_o;

  timer_scoreboard board;
  int unsigned cycles;
  int          idle_pct;

  timer_deadline_priority_queue uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[timer_deadline_priority_queue] ERROR");
      $finish;
    end
    if (rst_ni && valid_o)
      board.check_answer({status_o, task_valid_o, out_kind_o, out_tag_o,
                          due_sec_o, due_usec_o, occupancy_o});
  end

  task automatic write_reg(reg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.delay_reg[idx] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(op_e op, logic [31:0] ns, logic [19:0] nu, logic [2:0] kind,
                           logic [22:0] dms, logic [15:0] rnd, logic [15:0] tag);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start         <= 1'b1;
    opcode_i      <= op;
    now_sec_i     <= ns;
    now_usec_i    <= nu;
    task_kind_i   <= kind;
    delay_ms_i    <= dms;
    random_word_i <= rnd;
    user_tag_i    <= tag;
    do @(posedge clk_i); while (busy);
    board.note_item(op, ns, nu, kind, dms, rnd, tag);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic random_items(int count);
    op_e op;
    logic [31:0] base_s;
    logic [19:0] nu;
    base_s = $urandom;
    repeat (count) begin
      op = op_e'($urandom_range(3));
      if ($urandom_range(9) < 6) op = op_e'($urandom_range(1));
      nu = ($urandom_range(19) == 0) ? 20'($urandom) : 20'($urandom_range(999999));
      send_item(op, ($urandom_range(9) == 0) ? $urandom : base_s + $urandom_range(3),
                nu, 3'($urandom), ($urandom_range(3) == 0) ? 23'($urandom) :
                23'($urandom_range(2000)), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    board = new();
    board.clear();
    cycles = 0;
    idle_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(OP_POP, 0, 0, 0, 0, 0, 0);
    send_item(OP_PEEK, 0, 0, 0, 0, 0, 0);
    for (int k = 0; k < 8; k++)
      send_item(OP_ADD_KIND, 32'd100, 20'd999999, 3'(k), 0, 16'hFFFF, 16'(k));
    send_item(OP_ADD_MS, 32'hFFFF_FFFF, 20'hFFFFF, 0, 23'h7FFFFF, 0, 16'hFFFF);
    send_item(OP_ADD_MS, 32'd100, 20'd999999, 3'd7, 0, 0, 16'h1234);
    send_item(OP_ADD_MS, 32'd100, 20'd999999, 3'd6, 0, 0, 16'h5678);
    send_item(OP_ADD_KIND, 0, 0, 0, 0, 0, 16'hAAAA);
    for (int k = 0; k < 5; k++) send_item(OP_ADD_MS, $urandom, 0, 3'd5, 23'd1, 0, 0);
    send_item(OP_ADD_KIND, 0, 0, 0, 0, 0, 0);
    send_item(OP_PEEK, 0, 0, 0, 0, 0, 0);
    repeat (17) send_item(OP_POP, 0, 0, 0, 0, 0, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 56 : (phase == 3) ? 19 : 0;
      for (int r = 0; r < NumCfgRegs; r++)
        write_reg(reg_e'(r), (phase == 0) ? 32'hFFFF_FFFF : (phase == 1) ? 32'd0 :
                  $urandom_range(20000000));
      random_items(500);
      repeat (Depth + 1) send_item(OP_POP, 0, 0, 0, 0, 0, 0);
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("[timer_deadline_priority_queue] OK");
    end else begin
      $display("[timer_deadline_priority_queue] ERROR");
    end
    $finish;
  end
endmodule
